// ===== src/wmd_pkg.sv =====
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the window median depth sampler.
// ----------------------------------------------------------------------------
package wmd_pkg;

    localparam int CENTER_W   = 12;
    localparam int DEPTH_W    = 16;
    localparam int SIZE_W     = 11;
    localparam int RADIUS_W   = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int COORD_W    = CENTER_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 11'd480;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd1;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // beat taken this cycle
        logic shift;    // move sorted cells one place toward cell 0
        logic emit;     // register result, restart window
    } wmd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_item;   // current offsets sit on the last window position
        logic drain_done;  // median has reached cell 0
    } wmd_status_t;

endpackage

// ===== src/window_median_depth_sample.sv =====
// ----------------------------------------------------------------------------
// window_median_depth_sample
// Upper median of the nonzero in-image depths of a square window, in mm.
// ----------------------------------------------------------------------------
// Timing: the last window beat's edge starts a drain with busy high, in which
// the cells step toward cell 0 until the median sits in cell 0; the emit is
// then registered onto the result beat. Other beats give no result.
// Throughput: one beat per cycle while busy is low; a window takes its beats
// and then its drain, and no beat is taken during the drain. The receiver cannot stall.
// Reset (async, active low): 640x480, radius 1, window restarted; cells undefined.
// ----------------------------------------------------------------------------
module window_median_depth_sample
#(
    parameter  int MAX_RADIUS = 4,
    localparam int STORE      = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1),
    localparam int CNT_W      = $clog2(STORE + 1)
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // beat channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [wmd_pkg::CENTER_W-1:0]  center_u,
    input  logic signed [wmd_pkg::CENTER_W-1:0]  center_v,
    input  logic [wmd_pkg::DEPTH_W-1:0]          pixel_depth,
    // config write port
    input  logic                                 cfg_write,
    input  logic [wmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wmd_pkg::CFG_DATA_W-1:0]       cfg_data,
    // result channel
    output logic                                 done,
    output logic [wmd_pkg::DEPTH_W-1:0]          median_depth_mm,
    output logic                                 depth_valid,
    output logic [CNT_W-1:0]                     valid_count
);
    import wmd_pkg::*;

    wmd_cmd_t    cmd;
    wmd_status_t status;

    // Sequencer: IDLE takes beats, DRAIN shifts cells until the median
    // (index c/2) sits in cell 0 and then fires the result.
    wmd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: per beat, the pixel coordinate is centre + offset and is
    // checked against the live image size; a nonzero in-image depth goes
    // into the sorted cell row in the same cycle (every cell compares in
    // parallel). The centre check for the result uses the last beat's centre.
    wmd_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .center_u        (center_u),
        .center_v        (center_v),
        .pixel_depth     (pixel_depth),
        .cmd             (cmd),
        .status          (status),
        .done            (done),
        .median_depth_mm (median_depth_mm),
        .depth_valid     (depth_valid),
        .valid_count     (valid_count)
    );

endmodule

// ===== src/wmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wmd_ctrl
// Sequencer: takes beats while idle, walks the median down after the last
// window beat, then fires the result.
// ----------------------------------------------------------------------------
module wmd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  wmd_pkg::wmd_status_t status,
    output wmd_pkg::wmd_cmd_t    cmd,
    output logic                 busy
);
    import wmd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && status.last_item)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.drain_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.accept = start && (state_reg == ST_IDLE);
    assign cmd.shift  = (state_reg == ST_DRAIN) && !status.drain_done;
    assign cmd.emit   = (state_reg == ST_DRAIN) && status.drain_done;

endmodule

// ===== src/wmd_datapath.sv =====
// ----------------------------------------------------------------------------
// wmd_datapath
// Config registers, window offset counters, sorted insertion cell row,
// drain counter and result registers.
// ----------------------------------------------------------------------------
module wmd_datapath
#(
    parameter  int MAX_RADIUS = 4,
    localparam int STORE      = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1),
    localparam int CNT_W      = $clog2(STORE + 1)
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [wmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wmd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [wmd_pkg::CENTER_W-1:0]  center_u,
    input  logic signed [wmd_pkg::CENTER_W-1:0]  center_v,
    input  logic [wmd_pkg::DEPTH_W-1:0]          pixel_depth,
    input  wmd_pkg::wmd_cmd_t                    cmd,
    output wmd_pkg::wmd_status_t                 status,
    output logic                                 done,
    output logic [wmd_pkg::DEPTH_W-1:0]          median_depth_mm,
    output logic                                 depth_valid,
    output logic [CNT_W-1:0]                     valid_count
);
    import wmd_pkg::*;

    localparam int RAD_W = $clog2(MAX_RADIUS + 2);
    localparam int OFS_W = RAD_W + 1;
    localparam int RST_R = (int'(RADIUS_RESET) > MAX_RADIUS) ? MAX_RADIUS
                                                             : int'(RADIUS_RESET);
    localparam logic signed [OFS_W-1:0] OFS_RESET = OFS_W'(-RST_R);

    function automatic logic in_range(logic signed [COORD_W-1:0] c,
                                      logic [SIZE_W-1:0] lim);
        in_range = !c[COORD_W-1] && (c[COORD_W-2:0] < (COORD_W-1)'(lim));
    endfunction

    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic                radius_wr;
    logic [RADIUS_W-1:0] radius_sel;
    logic [RAD_W-1:0]    r_eff;
    logic signed [OFS_W-1:0] r_pos;
    logic signed [OFS_W-1:0] r_neg;

    logic signed [OFS_W-1:0] col_reg;
    logic signed [OFS_W-1:0] row_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        drain_reg;
    logic                    center_ok_reg;
    logic                    restart;

    logic signed [COORD_W-1:0] pix_col;
    logic signed [COORD_W-1:0] pix_row;
    logic                      ins;
    logic                      last_beat;

    logic [DEPTH_W-1:0] cell_reg [STORE];
    logic [STORE-1:0]   le;
    logic               result_ok;

    logic                done_reg;
    logic [DEPTH_W-1:0]  median_reg;
    logic                valid_reg;
    logic [CNT_W-1:0]    count_reg;

    // ---- config ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[SIZE_W-1:0];
                REG_WINDOW_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                default:           ;
            endcase
        end
    end

    // a radius write restarts the window with the new radius
    assign radius_wr  = cfg_write && (cfg_index == REG_WINDOW_RADIUS);
    assign radius_sel = radius_wr ? cfg_data[RADIUS_W-1:0] : radius_reg;

    always_comb
    begin
        if (int'(radius_sel) > MAX_RADIUS)
        begin
            r_eff = RAD_W'(MAX_RADIUS);
        end
        else
        begin
            r_eff = RAD_W'(radius_sel);
        end
    end

    assign r_pos   = signed'({1'b0, r_eff});
    assign r_neg   = -r_pos;
    assign restart = radius_wr || cmd.emit;

    // ---- pixel classification ----
    assign pix_col = COORD_W'(center_u) + COORD_W'(col_reg);
    assign pix_row = COORD_W'(center_v) + COORD_W'(row_reg);

    assign status.last_item = (col_reg == r_pos) && (row_reg == r_pos);
    assign last_beat        = cmd.accept && status.last_item;

    assign ins = cmd.accept && (pixel_depth != '0) && (cnt_reg < CNT_W'(STORE))
                 && in_range(pix_col, width_reg) && in_range(pix_row, height_reg);

    assign cnt_next = cnt_reg + CNT_W'(ins);

    // ---- window position ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= OFS_RESET;
            row_reg <= OFS_RESET;
        end
        else if (restart)
        begin
            col_reg <= r_neg;
            row_reg <= r_neg;
        end
        else if (cmd.accept)
        begin
            if (col_reg != r_pos)
            begin
                col_reg <= col_reg + OFS_W'(1);
            end
            else
            begin
                col_reg <= r_neg;
                if (row_reg != r_pos)
                begin
                    row_reg <= row_reg + OFS_W'(1);
                end
                else
                begin
                    row_reg <= r_neg;
                end
            end
        end
    end

    // ---- fill count, drain counter, centre check ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            drain_reg     <= '0;
            center_ok_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
            end

            if (last_beat)
            begin
                drain_reg     <= cnt_next >> 1;
                center_ok_reg <= in_range(COORD_W'(center_u), width_reg)
                                 && in_range(COORD_W'(center_v), height_reg);
            end
            else if (cmd.shift)
            begin
                drain_reg <= drain_reg - CNT_W'(1);
            end
        end
    end

    assign status.drain_done = (drain_reg == '0);

    // ---- sorted cell row: one insert per beat, one step down per drain cycle ----
    for (genvar i = 0; i < STORE; i++)
    begin : g_cell
        assign le[i] = (CNT_W'(i) < cnt_reg) && (cell_reg[i] <= pixel_depth);

        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (cmd.shift)
                begin
                    cell_reg[i] <= cell_reg[(STORE > 1) ? 1 : 0];
                end
                else if (ins && !le[i])
                begin
                    cell_reg[i] <= pixel_depth;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (cmd.shift)
                begin
                    cell_reg[i] <= cell_reg[(i + 1 < STORE) ? i + 1 : i];
                end
                else if (ins && !le[i])
                begin
                    cell_reg[i] <= le[i-1] ? pixel_depth : cell_reg[i-1];
                end
            end
        end
    end

    // ---- result ----
    assign result_ok = center_ok_reg && (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            median_reg <= result_ok ? cell_reg[0] : '0;
            valid_reg  <= result_ok;
            count_reg  <= result_ok ? cnt_reg : '0;
        end
    end

    assign done            = done_reg;
    assign median_depth_mm = median_reg;
    assign depth_valid     = valid_reg;
    assign valid_count     = count_reg;

endmodule

// ===== src/wmd_checker.sv =====
// ----------------------------------------------------------------------------
// wmd_checker
// Port-level checks on the result strobe and busy sequencing.
// ----------------------------------------------------------------------------
module wmd_checker
#(
    parameter  int MAX_RADIUS = 4,
    localparam int STORE      = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1),
    localparam int CNT_W      = $clog2(STORE + 1)
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 busy,
    input logic                                 done,
    input logic [wmd_pkg::DEPTH_W-1:0]          median_depth_mm,
    input logic                                 depth_valid,
    input logic [CNT_W-1:0]                     valid_count
);

    // end of drain always hands over a result
    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    // a result only follows a drain
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat without a preceding drain");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !depth_valid) |-> (median_depth_mm == '0 && valid_count == '0))
        else $error("invalid result carries nonzero fields");

    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && depth_valid) |-> (median_depth_mm != '0 && valid_count != '0))
        else $error("valid result with zero depth or zero count");

endmodule

bind window_median_depth_sample wmd_checker #(.MAX_RADIUS(MAX_RADIUS)) u_wmd_checker (.*);

// ===== tb/sv/tb_window_median_depth_sample.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_median_depth_sample
// Self-checking bench for the window median depth sampler: a scoreboard
// keeps its own copy of the sorted window store and register file, predicts
// one result per completed window and checks every done pulse against it.
// ----------------------------------------------------------------------------
module tb_window_median_depth_sample;

    import wmd_pkg::*;

    localparam int RADIUS_CAP   = 4;                      // matches MAX_RADIUS of the dut
    localparam int WINDOW_CELLS = (2 * RADIUS_CAP + 1) * (2 * RADIUS_CAP + 1);
    localparam int SETTLE_WAIT  = 2 + WINDOW_CELLS / 2 + 8; // drain time after a last beat
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;    // no register behind this index

    typedef struct packed {
        logic [DEPTH_W-1:0] med;
        logic               vld;
        logic [6:0]         cnt;
    } median_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own register copies, own sorted store, queue of medians due
    // ------------------------------------------------------------------------
    class median_board;
        int unsigned        img_w;
        int unsigned        img_h;
        int unsigned        radius;
        logic [DEPTH_W-1:0] depths[WINDOW_CELLS];
        int                 fill;
        int                 off_col;
        int                 off_row;
        median_result_t     due_medians[$];
        int                 errors;

        function new();
            img_w  = WIDTH_RESET;
            img_h  = HEIGHT_RESET;
            radius = RADIUS_RESET;
            errors = 0;
            restart_window();
        endfunction

        function int eff_radius();
            return (radius > RADIUS_CAP) ? RADIUS_CAP : int'(radius);
        endfunction

        function void restart_window();
            off_col = -eff_radius();
            off_row = -eff_radius();
            fill    = 0;
        endfunction

        function bit in_image(int col, int row);
            return col >= 0 && row >= 0 && col < int'(img_w) && row < int'(img_h);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:   img_w = data;
                REG_IMAGE_HEIGHT:  img_h = data;
                REG_WINDOW_RADIUS:
                begin
                    radius = data[RADIUS_W-1:0];
                    restart_window();
                end
                default: ;
            endcase
        endfunction

        // one accepted beat: insert its depth, step the window, maybe owe a result
        function void note_beat(logic signed [CENTER_W-1:0] cu,
                                logic signed [CENTER_W-1:0] cv,
                                logic [DEPTH_W-1:0] d);
            int             cu_i;
            int             cv_i;
            int             r;
            int             i;
            median_result_t res;
            cu_i = int'(cu);
            cv_i = int'(cv);
            r    = eff_radius();
            if (in_image(cu_i + off_col, cv_i + off_row) && d != '0 && fill < WINDOW_CELLS)
            begin
                i = fill;
                while (i > 0 && depths[i-1] > d)
                begin
                    depths[i] = depths[i-1];
                    i--;
                end
                depths[i] = d;
                fill++;
            end
            if (off_col < r)
            begin
                off_col++;
                return;
            end
            off_col = -r;
            if (off_row < r)
            begin
                off_row++;
                return;
            end
            res = '0;
            if (in_image(cu_i, cv_i) && fill > 0)
            begin
                res.med = depths[fill / 2];
                res.vld = 1'b1;
                res.cnt = 7'(fill);
            end
            due_medians.insert(due_medians.size(), res);
            restart_window();
        endfunction

        function void check_result(logic [DEPTH_W-1:0] med, logic vld, logic [6:0] cnt);
            median_result_t want;
            if (due_medians.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result median %0d valid %0d count %0d",
                         $time, med, vld, cnt);
                return;
            end
            want = due_medians.pop_front();
            if (med !== want.med)
            begin
                errors++;
                $display("%0t: median_depth_mm expected %0d actual %0d", $time, want.med, med);
            end
            if (vld !== want.vld)
            begin
                errors++;
                $display("%0t: depth_valid expected %0d actual %0d", $time, want.vld, vld);
            end
            if (cnt !== want.cnt)
            begin
                errors++;
                $display("%0t: valid_count expected %0d actual %0d", $time, want.cnt, cnt);
            end
        endfunction

        function int pending();
            return due_medians.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [CENTER_W-1:0] center_u;
    logic signed [CENTER_W-1:0] center_v;
    logic [DEPTH_W-1:0]         pixel_depth;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       done;
    logic [DEPTH_W-1:0]         median_depth_mm;
    logic                       depth_valid;
    logic [6:0]                 valid_count;

    window_median_depth_sample dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .center_u        (center_u),
        .center_v        (center_v),
        .pixel_depth     (pixel_depth),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .median_depth_mm (median_depth_mm),
        .depth_valid     (depth_valid),
        .valid_count     (valid_count)
    );

    median_board board = new();
    int          idle_pct;      // chance in percent of a sender gap before a beat
    int          cycle_count = 0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: all sampling at the rising edge sees pre-edge values, so beat
    // acceptance, result strobes and register writes line up with the dut.
    // A result and a new beat may share an edge; the result belongs to an
    // older window, so checking first keeps the queue in order.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(median_depth_mm, depth_valid, valid_count);
            if (start && !busy)
                board.note_beat(center_u, center_v, pixel_depth);
            if (cfg_write)
                board.write_reg(cfg_index, cfg_data);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one beat and hold it until taken. start stays high on exit so
    // back-to-back beats need no second assignment in the same step.
    task automatic push_beat(input logic signed [CENTER_W-1:0] cu,
                             input logic signed [CENTER_W-1:0] cv,
                             input logic [DEPTH_W-1:0] d);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        start       <= 1'b1;
        center_u    <= cu;
        center_v    <= cv;
        pixel_depth <= d;
        do @(posedge clk); while (busy);
    endtask

    // Wait until the block is quiet and every owed median has come back, then
    // give a window without a result time to finish its drain.
    task automatic settle_block();
        start <= 1'b0;
        do @(posedge clk); while (busy || board.pending() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // cfg_write stays high across a series of writes; caller drops it after
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // radius register holds 3 bits; junk in the upper data bits must not matter
    function automatic logic [CFG_DATA_W-1:0] radius_word(int r);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom);
        w[RADIUS_W-1:0] = RADIUS_W'(r);
        return w;
    endfunction

    // centre coordinate: mostly inside, some hugging the border, some anywhere
    function automatic logic signed [CENTER_W-1:0] pick_axis(int size, int r);
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 60 && size > 0)
            v = $urandom_range(size - 1);
        else if (sel < 82)
            v = -r - 1 + int'($urandom_range(size + 2 * r + 2));
        else
            v = int'($urandom_range(4095)) - 2048;
        if (v > 2047)
            v = 2047;
        return CENTER_W'(v);
    endfunction

    function automatic logic [DEPTH_W-1:0] pick_depth();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
            return '0;                                   // no depth
        else if (sel < 30)
            return '1;
        else if (sel < 40)
            return DEPTH_W'($urandom_range(15, 1));
        else if (sel < 50)
            return DEPTH_W'(1000 + $urandom_range(3));   // heavy duplicates
        else
            return DEPTH_W'($urandom);
    endfunction

    // Directed opener: partial window cut by a radius write, single-pixel
    // windows at the extremes, empty image, tiny image, ignored index, and a
    // corner window with duplicate and extreme depths.
    task automatic run_directed();
        idle_pct = 0;
        // defaults 640x480 r1: three beats then a radius write restarts
        push_beat(12'sd10, 12'sd10, 16'd500);
        push_beat(12'sd10, 12'sd10, 16'd0);
        push_beat(12'sd10, 12'sd10, 16'hFFFF);
        settle_block();
        cfg_put(REG_WINDOW_RADIUS, radius_word(0));
        cfg_write <= 1'b0;
        // one-pixel windows
        push_beat(-12'sd2048, -12'sd2048, 16'hFFFF);    // centre outside, negative
        push_beat(12'sd2047, 12'sd2047, 16'd1);         // centre outside, past the edge
        push_beat(12'sd639, 12'sd479, 16'hFFFF);        // last in-image pixel
        push_beat(12'sd5, 12'sd5, 16'd0);               // no valid sample
        settle_block();
        cfg_put(REG_IMAGE_WIDTH, 11'd0);                // empty image
        cfg_write <= 1'b0;
        push_beat(12'sd0, 12'sd0, 16'd100);
        settle_block();
        cfg_put(REG_IMAGE_WIDTH, 11'd2047);
        cfg_put(REG_IMAGE_HEIGHT, 11'd0);
        cfg_write <= 1'b0;
        push_beat(12'sd0, 12'sd0, 16'd5);
        settle_block();
        cfg_put(REG_IMAGE_WIDTH, 11'd1);
        cfg_put(REG_IMAGE_HEIGHT, 11'd1);
        cfg_put(REG_UNUSED, 11'h7FF);                   // must be dropped
        cfg_write <= 1'b0;
        push_beat(12'sd0, 12'sd0, 16'd7);
        push_beat(12'sd1, 12'sd0, 16'd7);
        push_beat(12'sd0, 12'sd0, 16'd9);
        settle_block();
        cfg_put(REG_IMAGE_WIDTH, 11'd2047);
        cfg_put(REG_IMAGE_HEIGHT, 11'd2047);
        cfg_put(REG_WINDOW_RADIUS, 11'h7F9);            // r = 1 under junk bits
        cfg_write <= 1'b0;
        // corner window: only the lower right quadrant is in the image
        push_beat(12'sd0, 12'sd0, 16'hFFFF);
        push_beat(12'sd0, 12'sd0, 16'd1);
        push_beat(12'sd0, 12'sd0, 16'd0);
        push_beat(12'sd0, 12'sd0, 16'd300);
        push_beat(12'sd0, 12'sd0, 16'd300);
        push_beat(12'sd0, 12'sd0, 16'd2);
        push_beat(12'sd0, 12'sd0, 16'hFFFF);
        push_beat(12'sd0, 12'sd0, 16'd0);
        push_beat(12'sd0, 12'sd0, 16'd40000);
        settle_block();
    endtask

    // Random phase: set the image and window, then whole windows of random
    // content until the beat budget is used. A few windows move the centre
    // on every beat.
    task automatic run_phase(input int w, input int h, input int r, input int gap_pct,
                             input int budget);
        int                         sent;
        int                         er;
        int                         cells;
        bit                         drift;
        logic signed [CENTER_W-1:0] cu;
        logic signed [CENTER_W-1:0] cv;
        settle_block();
        cfg_put(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_put(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        cfg_put(REG_WINDOW_RADIUS, radius_word(r));
        cfg_write <= 1'b0;
        idle_pct = gap_pct;
        er    = (r > RADIUS_CAP) ? RADIUS_CAP : r;
        cells = (2 * er + 1) * (2 * er + 1);
        sent  = 0;
        while (sent < budget)
        begin
            drift = ($urandom_range(9) == 0);
            cu = pick_axis(w, er);
            cv = pick_axis(h, er);
            for (int k = 0; k < cells; k++)
            begin
                if (drift)
                begin
                    cu = pick_axis(w, er);
                    cv = pick_axis(h, er);
                end
                push_beat(cu, cv, pick_depth());
            end
            sent += cells;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        center_u    = '0;
        center_v    = '0;
        pixel_depth = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_pct    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        //        width height radius gap%  beats
        run_phase(640,  480,   2,     0,    150);
        run_phase(2047, 2047,  1,     57,   120);
        run_phase(1,    2047,  0,     0,    60);
        run_phase(24,   16,    4,     28,   162);
        run_phase(0,    480,   1,     57,   45);    // empty image
        run_phase(2047, 1,     7,     0,    81);    // oversized radius, one-row image
        run_phase(9,    9,     3,     57,   147);
        run_phase(320,  240,   1,     28,   54);
        run_phase(2000, 3,     5,     28,   81);    // oversized radius again
        run_phase(2047, 2047,  0,     0,    40);

        settle_block();
        if (board.pending() != 0)
        begin
            board.errors += board.pending();
            $display("%0t: %0d expected results never arrived", $time, board.pending());
        end
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
